[sv/njs_pkg.sv]
// Package for the nonpreemptive job scheduler: widths, payload structs and state type.
`default_nettype none
package njs_pkg;

  localparam int FIELD_W      = 16;
  localparam int TIME_W       = 23;
  localparam int MAX_JOBS_DEF = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] arrival_time;
    logic [FIELD_W-1:0] burst_time;
    logic               last_job;
  } njs_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] job_arrival;
    logic [FIELD_W-1:0] job_burst;
    logic [TIME_W-1:0]  completion_time;
    logic [TIME_W-1:0]  turnaround_time;
    logic [TIME_W-1:0]  waiting_time;
    logic               last_result;
  } njs_out_t;

  typedef struct packed {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } njs_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } njs_state_t;

endpackage
`default_nettype wire

[sv/nonpreemptive_job_scheduler_unit.sv]
// Top level of the nonpreemptive FCFS / SJF job scheduler.
// Loading: one job per cycle; busy stays low, a transaction is taken every cycle.
// Run (job flagged last): per result, a scan of the n stored jobs through the job memory
// read port in the SCAN state, then a selection in the EMIT state; n results per run.
// Each result strobes out_valid in the cycle after its selection; the receiver cannot stall.
// Reset (rst_n low, synchronous): idle, store empty, policy SJF; job memory not cleared.
`default_nettype none
module nonpreemptive_job_scheduler_unit #(
  parameter int MAX_JOBS = njs_pkg::MAX_JOBS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire njs_pkg::njs_in_t  in_data,
  output logic                   out_valid,
  output njs_pkg::njs_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_policy_mode
);

  import njs_pkg::*;

  // Index width covers the memory depth; count width can also hold MAX_JOBS itself.
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

  // Scheduling order: true when job x (loaded earlier) goes before job y.
  function automatic logic goes_first(
    input logic [FIELD_W-1:0] ax,
    input logic [FIELD_W-1:0] bx,
    input logic [FIELD_W-1:0] ay,
    input logic [FIELD_W-1:0] by,
    input logic [TIME_W-1:0]  now,
    input logic               sjf
  );
    logic inx;
    logic iny;
    logic res;
    inx = (TIME_W'(ax) <= now);
    iny = (TIME_W'(ay) <= now);
    if (sjf && inx && iny) begin
      if (bx != by) res = (bx < by);
      else          res = (ax <= ay);
    end else if (sjf && (inx != iny)) begin
      res = inx;
    end else begin
      if (ax != ay) res = (ax < ay);
      else          res = (bx <= by);
    end
    return res;
  endfunction

  // Job memory: one write port for loading, one registered read port for scanning.
  njs_job_t mem [MAX_JOBS];
  njs_job_t rd_data_r;

  njs_state_t           state_r, state_nxt;
  logic                 mode_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     issue_idx_r;
  logic [CNT_W-1:0]     emit_cnt_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_tag_r;
  logic [MAX_JOBS-1:0]  done_r;
  logic [TIME_W-1:0]    clock_r;
  logic                 have_best_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [FIELD_W-1:0]   best_a_r;
  logic [FIELD_W-1:0]   best_b_r;
  logic                 out_valid_r;
  njs_out_t             out_data_r;

  logic accept;
  logic load_en;
  logic run_go;
  logic issue_en;
  logic scan_last;
  logic take;
  logic emit_last;

  logic [TIME_W-1:0] a_ext;
  logic [TIME_W-1:0] b_ext;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] finish_time;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (run_go)    state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = emit_last ? ST_IDLE : ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy      = 1'b1;
    load_en   = 1'b0;
    run_go    = 1'b0;
    issue_en  = 1'b0;
    scan_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        load_en = accept && (count_r < MAX_CNT);
        run_go  = accept && in_data.last_job;
      end
      ST_SCAN: begin
        issue_en  = (issue_idx_r < count_r);
        scan_last = rd_vld_r && (CNT_W'(rd_tag_r) == count_r - CNT_W'(1));
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Compare the job just read against the best so far; skip scheduled jobs.
  assign take = rd_vld_r && !done_r[rd_tag_r] &&
                (!have_best_r ||
                 !goes_first(best_a_r, best_b_r, rd_data_r.arrival, rd_data_r.burst,
                             clock_r, mode_r));

  // Timing of the selected job: jump an idle clock forward, then add the burst.
  assign a_ext       = TIME_W'(best_a_r);
  assign b_ext       = TIME_W'(best_b_r);
  assign start_time  = (clock_r < a_ext) ? a_ext : clock_r;
  assign finish_time = start_time + b_ext;
  assign emit_last   = (emit_cnt_r + CNT_W'(1) == count_r);

  // Job memory write and registered read.
  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[count_r[IDX_W-1:0]] <= '{arrival: in_data.arrival_time, burst: in_data.burst_time};
    end
    if (issue_en) begin
      rd_data_r <= mem[issue_idx_r[IDX_W-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b1;
      count_r     <= '0;
      issue_idx_r <= '0;
      emit_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      done_r      <= '0;
      clock_r     <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= issue_en;
      out_valid_r <= (state_r == ST_EMIT);
      if (cfg_valid && cfg_ready) mode_r <= cfg_policy_mode;
      if (load_en) count_r <= count_r + CNT_W'(1);
      if (run_go) begin
        // clear the done marks, the clock and the scan counters for the new run
        done_r      <= '0;
        clock_r     <= '0;
        emit_cnt_r  <= '0;
        issue_idx_r <= '0;
        have_best_r <= 1'b0;
      end
      if (issue_en) issue_idx_r <= issue_idx_r + CNT_W'(1);
      if (take) have_best_r <= 1'b1;
      if (state_r == ST_EMIT) begin
        done_r[best_idx_r] <= 1'b1;
        clock_r            <= finish_time;
        emit_cnt_r         <= emit_cnt_r + CNT_W'(1);
        issue_idx_r        <= '0;
        have_best_r        <= 1'b0;
        if (emit_last) count_r <= '0;
      end
    end
  end

  // Payload registers: best candidate and the result transaction.
  always_ff @(posedge clk) begin
    if (issue_en) rd_tag_r <= issue_idx_r[IDX_W-1:0];
    if (take) begin
      best_idx_r <= rd_tag_r;
      best_a_r   <= rd_data_r.arrival;
      best_b_r   <= rd_data_r.burst;
    end
    if (state_r == ST_EMIT) begin
      out_data_r.job_arrival     <= best_a_r;
      out_data_r.job_burst       <= best_b_r;
      out_data_r.completion_time <= finish_time;
      out_data_r.turnaround_time <= finish_time - a_ext;
      out_data_r.waiting_time    <= start_time - a_ext;
      out_data_r.last_result     <= emit_last;
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the nonpreemptive FCFS / SJF job scheduler.
`default_nettype none
module tb_top;
  import njs_pkg::*;

  localparam int  JOBS          = njs_pkg::MAX_JOBS_DEF;
  localparam bit  POLICY_FCFS   = 1'b0;
  localparam bit  POLICY_SJF    = 1'b1;
  localparam int  SETTLE_CYCLES = 4;     // quiet time after the last entry before a policy write
  localparam int  TAIL_CYCLES   = 40;    // watch for stray entries once all are in
  localparam int  STALL_LIMIT   = 5000;  // quiet limit; the longest run (32 jobs) moves something well within it
  localparam int  PHASE_JOBS    = 108;

  typedef enum int {MIX_WIDE, MIX_TIES, MIX_SPREAD, MIX_EDGES} job_mix_t;

  // One row of the directed table: the job, an optional policy write before it,
  // and, for single-job sets, the schedule entry typed in by hand.
  typedef struct packed {
    njs_in_t  job;
    logic     set_policy;
    logic     policy;
    logic     typed;
    njs_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  njs_in_t  in_data = '0;
  logic     out_valid;
  njs_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_policy_mode = 1'b0;

  // Scheduler mirror: job store, fill level and policy
  logic [FIELD_W-1:0] held_arrival [JOBS];
  logic [FIELD_W-1:0] held_burst   [JOBS];
  int                 jobs_held = 0;
  logic               policy_sjf = POLICY_SJF;

  njs_out_t sched_q[$];    // schedule entries still owed by the block
  dir_row_t dir_rows[$];

  int mismatches = 0;
  int entries_checked = 0;
  int jobs_sent = 0;
  int runs_started = 0;
  int overflow_sets = 0;
  int policy_writes = 0;
  int stall_cycles = 0;

  nonpreemptive_job_scheduler_unit #(.MAX_JOBS(JOBS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_policy_mode (cfg_policy_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True when held job x is to be served before held job y (x loaded earlier).
  function automatic bit serves_first(int x, int y, logic [TIME_W-1:0] now);
    logic [FIELD_W-1:0] ax, bx, ay, by;
    bit                 x_in, y_in;
    ax = held_arrival[x];
    bx = held_burst[x];
    ay = held_arrival[y];
    by = held_burst[y];
    if (policy_sjf == POLICY_SJF) begin
      x_in = (TIME_W'(ax) <= now);
      y_in = (TIME_W'(ay) <= now);
      // among arrived jobs the shortest burst wins, then the earlier arrival
      if (x_in && y_in) begin
        if (bx != by) return bx < by;
        if (ax != ay) return ax < ay;
        return 1'b1;
      end
      if (x_in != y_in) return x_in;
    end
    // FCFS order, also SJF when nothing has arrived yet
    if (ax != ay) return ax < ay;
    if (bx != by) return bx < by;
    return 1'b1;
  endfunction

  // Store one accepted job; on the flagged last job, build the whole schedule.
  function automatic void take_job(njs_in_t job);
    bit                served [JOBS];
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] fin;
    int                pick;
    njs_out_t          entry;
    if (jobs_held < JOBS) begin
      held_arrival[jobs_held] = job.arrival_time;
      held_burst[jobs_held]   = job.burst_time;
      jobs_held++;
    end
    if (!job.last_job) return;
    runs_started++;
    foreach (served[i]) served[i] = 1'b0;
    now = '0;
    for (int k = 0; k < jobs_held; k++) begin
      pick = -1;
      for (int i = 0; i < jobs_held; i++) begin
        if (served[i]) continue;
        if (pick < 0 || !serves_first(pick, i, now)) pick = i;
      end
      served[pick] = 1'b1;
      // jump an idle clock forward to the arrival
      if (now < TIME_W'(held_arrival[pick])) now = TIME_W'(held_arrival[pick]);
      fin = now + TIME_W'(held_burst[pick]);
      now = fin;
      entry.job_arrival     = held_arrival[pick];
      entry.job_burst       = held_burst[pick];
      entry.completion_time = fin;
      entry.turnaround_time = fin - TIME_W'(held_arrival[pick]);
      entry.waiting_time    = fin - TIME_W'(held_arrival[pick]) - TIME_W'(held_burst[pick]);
      entry.last_result     = (k == jobs_held - 1);
      sched_q.insert(sched_q.size(), entry);
    end
    jobs_held = 0;
  endfunction

  function automatic dir_row_t mk_row(logic [15:0] arr, logic [15:0] bst, logic last,
                                      logic set_policy, logic policy, logic typed,
                                      logic [22:0] fin, logic [22:0] tat, logic [22:0] wait_t);
    dir_row_t row;
    row.job.arrival_time      = arr;
    row.job.burst_time        = bst;
    row.job.last_job          = last;
    row.set_policy            = set_policy;
    row.policy                = policy;
    row.typed                 = typed;
    row.want.job_arrival      = arr;
    row.want.job_burst        = bst;
    row.want.completion_time  = fin;
    row.want.turnaround_time  = tat;
    row.want.waiting_time     = wait_t;
    row.want.last_result      = 1'b1;
    return row;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [FIELD_W-1:0] draw_time(job_mix_t mix, bit is_arrival);
    case (mix)
      MIX_TIES:   return is_arrival ? FIELD_W'($urandom_range(0, 15))
                                    : FIELD_W'($urandom_range(0, 7));
      MIX_SPREAD: return is_arrival ? FIELD_W'($urandom_range(0, 65535))
                                    : FIELD_W'($urandom_range(0, 31));
      MIX_EDGES: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return FIELD_W'($urandom_range(0, 65535));
        endcase
      end
      default:    return FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one job, idling first now and then; return at the edge that takes it.
  // Start is left high so the next job can follow back to back.
  task automatic send_job(njs_in_t job, int idle_pct, logic typed, njs_out_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= job;
    @(posedge clk);
    while (busy) @(posedge clk);
    jobs_sent++;
    take_job(job);
    // hand-typed rows replace the mirror's single entry
    if (typed) begin
      void'(sched_q.pop_back());
      sched_q.insert(sched_q.size(), want);
    end
  endtask

  // Drop start, let the block go quiet, then write the policy register.
  task automatic write_policy(logic policy);
    start <= 1'b0;
    @(posedge clk);
    while (sched_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_policy_mode <= policy;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    policy_sjf = policy;
    policy_writes++;
  endtask

  // Check every strobed schedule entry against the oldest one owed.
  always @(posedge clk) begin
    njs_out_t want;
    if (rst_n && out_valid) begin
      if (sched_q.size() == 0) begin
        $error("schedule entry with none owed: arrival %0d burst %0d",
               out_data.job_arrival, out_data.job_burst);
        mismatches++;
      end else begin
        want = sched_q.pop_front();
        entries_checked++;
        check_field("job_arrival", want.job_arrival, out_data.job_arrival);
        check_field("job_burst", want.job_burst, out_data.job_burst);
        check_field("completion_time", want.completion_time, out_data.completion_time);
        check_field("turnaround_time", want.turnaround_time, out_data.turnaround_time);
        check_field("waiting_time", want.waiting_time, out_data.waiting_time);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("nonpreemptive_job_scheduler_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int       idle_pct;
    int       target;
    int       set_len;
    bit       first_set;
    job_mix_t mix;
    njs_in_t  job;

    // Directed table: single-job sets carry a hand-typed entry, the rest go
    // through the mirror. Policy stays at its reset value (SJF) for the first two.
    add_row(mk_row(16'd0, 16'd0, 1'b1, 1'b0, POLICY_SJF, 1'b1, 23'd0, 23'd0, 23'd0));
    add_row(mk_row(16'd65535, 16'd65535, 1'b1, 1'b0, POLICY_SJF, 1'b1,
                   23'd131070, 23'd65535, 23'd0));
    add_row(mk_row(16'd100, 16'd5, 1'b1, 1'b1, POLICY_SJF, 1'b1,
                   23'd105, 23'd5, 23'd0));
    // SJF: first job runs alone, then shortest burst among arrived, equal keys in load order
    add_row(mk_row(16'd0, 16'd10, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd1, 16'd2, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd1, 16'd2, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd2, 16'd1, 1'b1, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    // SJF with nothing arrived at zero: earliest arrival, then shortest burst
    add_row(mk_row(16'd50, 16'd4, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd20, 16'd9, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd20, 16'd3, 1'b1, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    // FCFS: arrival order, shorter burst on a tie, extremes of both fields
    add_row(mk_row(16'd5, 16'd3, 1'b0, 1'b1, POLICY_FCFS, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd5, 16'd1, 1'b0, 1'b0, POLICY_FCFS, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd0, 16'd65535, 1'b0, 1'b0, POLICY_FCFS, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd65535, 16'd0, 1'b1, 1'b0, POLICY_FCFS, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd7, 16'd7, 1'b1, 1'b0, POLICY_FCFS, 1'b1, 23'd14, 23'd7, 23'd0));
    add_row(mk_row(16'd0, 16'd1, 1'b0, 1'b0, POLICY_FCFS, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd0, 16'd1, 1'b0, 1'b0, POLICY_FCFS, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd0, 16'd1, 1'b1, 1'b0, POLICY_FCFS, 1'b0, '0, '0, '0));
    // SJF with large times: the clock climbs well past 16 bits
    add_row(mk_row(16'd0, 16'd65535, 1'b0, 1'b1, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd65535, 16'd65535, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd65535, 16'd65535, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd40000, 16'd65535, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd43690, 16'd21845, 1'b0, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));
    add_row(mk_row(16'd21845, 16'd43690, 1'b1, 1'b0, POLICY_SJF, 1'b0, '0, '0, '0));

    // Hold reset, then release it for good
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_policy) write_policy(dir_rows[r].policy);
      send_job(dir_rows[r].job, 34, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random sets in three idling phases: sender idles 34 %, then 70 %, then never.
    // Most sets are short; a few run up to a full store and some overflow it.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 34 : (phase == 1) ? 70 : 0;
      target    = jobs_sent + PHASE_JOBS;
      first_set = 1'b1;
      while (jobs_sent < target) begin
        if (first_set)
          write_policy(phase == 0 ? POLICY_FCFS :
                       phase == 1 ? POLICY_SJF : 1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 3) == 0)
          write_policy(1'($urandom_range(0, 1)));
        first_set = 1'b0;
        case ($urandom_range(0, 19))
          0:       set_len = $urandom_range(JOBS + 1, JOBS + 4);
          1, 2:    set_len = $urandom_range(9, JOBS);
          default: set_len = $urandom_range(1, 8);
        endcase
        if (set_len > JOBS) overflow_sets++;
        mix = job_mix_t'($urandom_range(0, 3));
        for (int j = 0; j < set_len; j++) begin
          job.arrival_time = draw_time(mix, 1'b1);
          job.burst_time   = draw_time(mix, 1'b0);
          job.last_job     = (j == set_len - 1);
          send_job(job, idle_pct, 1'b0, '0);
        end
      end
    end

    // Release start, wait for every owed entry, then watch for strays
    start <= 1'b0;
    @(posedge clk);
    while (sched_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Loaded %0d jobs over %0d runs (%0d sets overflowing the store),",
             jobs_sent, runs_started, overflow_sets);
    $display("%0d policy writes; checked %0d schedule entries field by field, %0d mismatches.",
             policy_writes, entries_checked, mismatches);
    if (mismatches == 0)
      $display("nonpreemptive_job_scheduler_unit test passed");
    else
      $display("nonpreemptive_job_scheduler_unit test failed");
    $finish;
  end

endmodule
`default_nettype wire
